// ===== rtl/dst_pkg.sv =====
// ============================================================================
// Dense slot table package
// Sizes, command and status codes, and the lookup result type shared by the
// dense slot table core and its key match unit.
// ============================================================================
package dst_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES  = 16;
    localparam int PAYLOAD_BITS = 64;

    // Fixed field widths of the ports.
    localparam int KEY_W      = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int COUNT_W    = 5;

    // Internal widths that follow from the table depth.
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // Result of a key lookup: whether a live keyed slot matched, and the lowest one.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_match;

endpackage

// ===== rtl/dst_match.sv =====
// ============================================================================
// Dense slot table key match
// Compares the lookup key against every slot in parallel and picks the lowest
// live, keyed slot that matches.
// ============================================================================
module dst_match
    import dst_pkg::*;
(
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_slot_key [MAX_ENTRIES],
    input  logic [MAX_ENTRIES-1:0] i_keyed,
    input  logic [CNT_W-1:0] i_count,
    output t_match           o_match
);

    // Walk from the top down so that the lowest matching slot is the one kept.
    always_comb begin
        o_match = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < i_count) && i_keyed[i] && (i_slot_key[i] == i_key)) begin
                o_match.hit = 1'b1;
                o_match.idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/dense_slot_table_swap_remove_core.sv =====
// ============================================================================
// Dense slot table with swap-remove
// Keeps a packed table of keyed payload words. Add appends, remove moves the
// last entry into the freed slot, update rewrites a payload, clear empties.
// ============================================================================
//
//  Channel   Signals                               Transfer
//  --------  ------------------------------------  ------------------------------
//  command   start, busy, i_cmd, i_key, i_payload  edge with start high, busy low
//  result    o_done, o_status, o_slot, o_count     edge ending the o_done cycle
//
// Every command goes from its transfer through the command register, where the
// parallel key compare and the table update are worked out, and then through
// the result register. A new command can be taken on every cycle that busy is
// low, since each update lands in the table at the same edge that loads the
// next command. busy is high only while reset is applied and for the cycle
// after it. The receiver cannot stall: a result is shown for one cycle only.
//
module dense_slot_table_swap_remove_core
    import dst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [PAYLOAD_W-1:0]  i_payload,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic [COUNT_W-1:0]    o_count
);

    // Command register.
    logic                    r_run;
    logic                    r_vld;
    logic [CMD_W-1:0]        r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Table state. Keys and payloads hold whatever was last written; only the
    // keyed bits and the entry count are cleared by reset.
    logic [PAYLOAD_BITS-1:0] r_slot_pl  [MAX_ENTRIES];
    logic [KEY_W-1:0]        r_slot_key [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  r_keyed;
    logic [CNT_W-1:0]        r_count;

    // Result register.
    logic                    r_done;
    logic [STATUS_W-1:0]     r_status;
    logic [SLOT_OUT_W-1:0]   r_slot;
    logic [COUNT_W-1:0]      r_count_out;

    // Next-state values worked out from the command register.
    logic [MAX_ENTRIES-1:0]  n_keyed;
    logic [CNT_W-1:0]        n_count;
    t_status                 n_status;
    logic [IDX_W-1:0]        n_slot;
    logic                    n_key_we;
    logic                    n_pl_we;
    logic [IDX_W-1:0]        n_wr_idx;
    logic [KEY_W-1:0]        n_wr_key;
    logic [PAYLOAD_BITS-1:0] n_wr_pl;

    t_match                  match;
    t_cmd                    cmd;
    logic                    full;
    logic [IDX_W-1:0]        tail_idx;
    logic [IDX_W-1:0]        last_idx;

    assign busy = !r_run;

    // Command register: takes a transfer on every cycle that busy is low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_run <= 1'b1;
            r_vld <= start && r_run;
        end
        if (start && r_run) begin
            r_cmd     <= i_cmd;
            r_key     <= i_key;
            r_payload <= PAYLOAD_BITS'(i_payload);
        end
    end

    // Parallel lookup of the registered key over the live slots.
    dst_match u_match (
        .i_key      (r_key),
        .i_slot_key (r_slot_key),
        .i_keyed    (r_keyed),
        .i_count    (r_count),
        .o_match    (match)
    );

    assign cmd      = t_cmd'(r_cmd);
    assign full     = (r_count >= CNT_W'(MAX_ENTRIES));
    // The slot just past the end; only used when the table is not full.
    assign tail_idx = r_count[IDX_W-1:0];
    // The last occupied slot; only used when a key was found, so the table is
    // not empty.
    assign last_idx = tail_idx - IDX_W'(1);

    always_comb begin
        n_keyed  = r_keyed;
        n_count  = r_count;
        n_status = ST_OK;
        n_slot   = '0;
        n_key_we = 1'b0;
        n_pl_we  = 1'b0;
        n_wr_idx = '0;
        n_wr_key = r_key;
        n_wr_pl  = r_payload;
        if (r_vld) begin
            unique case (cmd)
                CMD_CLEAR: begin
                    n_keyed = '0;
                    n_count = '0;
                end
                CMD_ADD: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        // A key that is already present is rebound: the old
                        // slot stays in the table but loses its key.
                        if (match.hit) begin
                            n_keyed[match.idx] = 1'b0;
                        end
                        n_keyed[tail_idx] = 1'b1;
                        n_key_we = 1'b1;
                        n_pl_we  = 1'b1;
                        n_wr_idx = tail_idx;
                        n_count  = r_count + CNT_W'(1);
                        n_slot   = tail_idx;
                    end
                end
                CMD_REMOVE: begin
                    if (!match.hit) begin
                        n_status = ST_MISSING;
                    end else begin
                        // Move the last entry into the freed slot, then drop
                        // the last slot.
                        if (match.idx != last_idx) begin
                            n_key_we = 1'b1;
                            n_pl_we  = 1'b1;
                            n_wr_idx = match.idx;
                            n_wr_key = r_slot_key[last_idx];
                            n_wr_pl  = r_slot_pl[last_idx];
                            n_keyed[match.idx] = r_keyed[last_idx];
                        end
                        n_keyed[last_idx] = 1'b0;
                        n_count = r_count - CNT_W'(1);
                        n_slot  = match.idx;
                    end
                end
                CMD_UPDATE: begin
                    if (!match.hit) begin
                        n_status = ST_MISSING;
                    end else begin
                        n_pl_we  = 1'b1;
                        n_wr_idx = match.idx;
                        n_slot   = match.idx;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Table state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyed <= '0;
            r_count <= '0;
        end else begin
            r_keyed <= n_keyed;
            r_count <= n_count;
        end
        if (n_key_we) begin
            r_slot_key[n_wr_idx] <= n_wr_key;
        end
        if (n_pl_we) begin
            r_slot_pl[n_wr_idx] <= n_wr_pl;
        end
    end

    // Result register: one strobe per command, loaded from the command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
        r_status    <= n_status;
        r_slot      <= SLOT_OUT_W'(n_slot);
        r_count_out <= COUNT_W'(n_count);
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_count  = r_count_out;

endmodule
